### hw/rtl/kvt_pkg.sv
// Shared types, codes and constants of the key/value line tokenizer.
package kvt_pkg;

  localparam int LEXEME_LIMIT = 255;
  localparam int MAX_TOKENS   = 256;
  localparam int MAX_RESULTS  = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_NUM    = 3'd1,
    ST_OSTR_E = 3'd2,
    ST_OSTR   = 3'd3,
    ST_STR    = 3'd4,
    ST_EQ     = 3'd5,
    ST_ID     = 3'd6,
    ST_COMMA  = 3'd7
  } lex_state_t;

  typedef enum logic [1:0] {
    EV_LEX    = 2'd0,
    EV_TOKEN  = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_REJECT = 2'd3
  } ev_t;

  typedef enum logic [2:0] {
    TOK_ID    = 3'd0,
    TOK_NUM   = 3'd1,
    TOK_STR   = 3'd2,
    TOK_EQ    = 3'd3,
    TOK_COMMA = 3'd4
  } tok_t;

  typedef enum logic [1:0] {
    ERR_UNEXPECTED = 2'd0,
    ERR_TOO_LONG   = 2'd1,
    ERR_NOT_ACCEPT = 2'd2
  } err_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] lex_byte;
    logic [2:0] token_type;
    logic [7:0] token_length;
    logic [8:0] token_total;
    logic [1:0] error_code;
    logic       last;
  } out_item_t;

  // All results caused by one byte, in order.
  typedef struct packed {
    logic [2:0]                        cnt;
    out_item_t [MAX_RESULTS-1:0]       res;
  } cmd_t;

  typedef struct packed {
    logic ok;
    lex_state_t st;
  } step_t;

endpackage

### hw/rtl/key_value_line_tokenizer.sv
// Key/value line tokenizer: one byte per cycle into the lexer; each result leaves
// on its own cycle. A byte is taken every cycle while the two-entry result queue
// has room; the output drains one item per cycle while out_ready is high, so the
// results of a byte (up to four) hold it until all are taken, and the front runs
// ahead by at most two such bytes. Bytes that cause no result (a space between
// tokens, or bytes skipped after a verdict) wait only on the queue's full flag.
module key_value_line_tokenizer import kvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic q_push, q_not_full, q_pop, q_not_empty;
  cmd_t q_wdata, q_head;

  kvt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_not_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  kvt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  kvt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/kvt_front.sv
// Front stage: DFA lexer step per byte, builds the result list for the back stage.
module kvt_front import kvt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_ready,
  output logic     q_push,
  output cmd_t     q_data
);

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic step_t lex_step(lex_state_t s, logic [7:0] c);
    step_t r;
    r.ok = 1'b0;
    r.st = ST_START;
    unique case (s) inside
      ST_START: begin
        if (is_digit(c) || c == CH_MINUS) begin
          r = '{ok: 1'b1, st: ST_NUM};
        end else if (is_letter(c)) begin
          r = '{ok: 1'b1, st: ST_ID};
        end else if (c == CH_QUOTE) begin
          r = '{ok: 1'b1, st: ST_OSTR_E};
        end else if (c == CH_EQ) begin
          r = '{ok: 1'b1, st: ST_EQ};
        end else if (c == CH_COMMA) begin
          r = '{ok: 1'b1, st: ST_COMMA};
        end
      end
      ST_ID: begin
        if (is_letter(c)) r = '{ok: 1'b1, st: ST_ID};
      end
      ST_NUM: begin
        if (is_digit(c)) r = '{ok: 1'b1, st: ST_NUM};
      end
      ST_OSTR_E, ST_OSTR: begin
        r = '{ok: 1'b1, st: (c == CH_QUOTE) ? ST_STR : ST_OSTR};
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_accepting(lex_state_t s);
    return s == ST_NUM || s == ST_STR || s == ST_EQ || s == ST_ID || s == ST_COMMA;
  endfunction

  function automatic tok_t type_of(lex_state_t s);
    tok_t t;
    unique case (s)
      ST_ID:   t = TOK_ID;
      ST_NUM:  t = TOK_NUM;
      ST_STR:  t = TOK_STR;
      ST_EQ:   t = TOK_EQ;
      default: t = TOK_COMMA;
    endcase
    return t;
  endfunction

  lex_state_t state_r, state_nxt;
  logic [7:0] lcnt_r, lcnt_nxt;
  logic [8:0] tcnt_r, tcnt_nxt;
  logic       skip_r, skip_nxt;

  cmd_t       plan;
  step_t      t;
  logic       verdict;
  logic       is_eol;
  logic       fire;
  logic [7:0] c;
  logic       eol_mark;

  assign c        = in_data.ch;
  assign eol_mark = in_data.line_end;
  assign is_eol   = (c == CH_CR) || (c == CH_LF);

  // Next state and result list.
  always_comb begin
    state_nxt = state_r;
    lcnt_nxt  = lcnt_r;
    tcnt_nxt  = tcnt_r;
    skip_nxt  = skip_r;
    plan      = '0;
    verdict   = 1'b0;
    t         = '0;
    if (skip_r) begin
      if (eol_mark) begin
        skip_nxt  = 1'b0;
        state_nxt = ST_START;
        lcnt_nxt  = '0;
        tcnt_nxt  = '0;
      end
    end else begin
      if (!is_eol) begin
        t = lex_step(state_nxt, c);
        if (!t.ok && state_nxt != ST_START) begin
          plan.res[plan.cnt[1:0]].event_res    = EV_TOKEN;
          plan.res[plan.cnt[1:0]].token_type   = type_of(state_nxt);
          plan.res[plan.cnt[1:0]].token_length = lcnt_nxt;
          plan.cnt = plan.cnt + 3'd1;
          if (tcnt_nxt < 9'(MAX_TOKENS)) tcnt_nxt = tcnt_nxt + 9'd1;
          state_nxt = ST_START;
          lcnt_nxt  = '0;
          t = lex_step(ST_START, c);
        end
        if (!t.ok) begin
          if (c != CH_SPACE) begin
            plan.res[plan.cnt[1:0]].event_res  = EV_REJECT;
            plan.res[plan.cnt[1:0]].error_code = ERR_UNEXPECTED;
            plan.cnt  = plan.cnt + 3'd1;
            state_nxt = ST_START;
            lcnt_nxt  = '0;
            tcnt_nxt  = '0;
            verdict   = 1'b1;
          end
        end else if (lcnt_nxt >= 8'(LEXEME_LIMIT)) begin
          plan.res[plan.cnt[1:0]].event_res  = EV_REJECT;
          plan.res[plan.cnt[1:0]].error_code = ERR_TOO_LONG;
          plan.cnt  = plan.cnt + 3'd1;
          state_nxt = ST_START;
          lcnt_nxt  = '0;
          tcnt_nxt  = '0;
          verdict   = 1'b1;
        end else begin
          if (t.st != ST_OSTR_E && t.st != ST_STR) begin
            plan.res[plan.cnt[1:0]].event_res = EV_LEX;
            plan.res[plan.cnt[1:0]].lex_byte  = c;
            plan.cnt = plan.cnt + 3'd1;
            lcnt_nxt = lcnt_nxt + 8'd1;
          end
          state_nxt = t.st;
        end
      end
      if (is_eol || (eol_mark && !verdict)) begin
        if (is_accepting(state_nxt)) begin
          plan.res[plan.cnt[1:0]].event_res    = EV_TOKEN;
          plan.res[plan.cnt[1:0]].token_type   = type_of(state_nxt);
          plan.res[plan.cnt[1:0]].token_length = lcnt_nxt;
          plan.cnt = plan.cnt + 3'd1;
          if (tcnt_nxt < 9'(MAX_TOKENS)) tcnt_nxt = tcnt_nxt + 9'd1;
          plan.res[plan.cnt[1:0]].event_res   = EV_ACCEPT;
          plan.res[plan.cnt[1:0]].token_total = tcnt_nxt;
          plan.cnt = plan.cnt + 3'd1;
        end else begin
          plan.res[plan.cnt[1:0]].event_res  = EV_REJECT;
          plan.res[plan.cnt[1:0]].error_code = ERR_NOT_ACCEPT;
          plan.cnt = plan.cnt + 3'd1;
        end
        state_nxt = ST_START;
        lcnt_nxt  = '0;
        tcnt_nxt  = '0;
        verdict   = 1'b1;
      end
      if (verdict && !eol_mark) skip_nxt = 1'b1;
      if (plan.cnt != 3'd0) plan.res[2'(plan.cnt - 3'd1)].last = 1'b1;
    end
  end

  // Outputs.
  always_comb begin
    in_ready = q_ready;
    fire     = in_valid && q_ready;
    q_push   = fire && (plan.cnt != 3'd0);
    q_data   = plan;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      lcnt_r  <= '0;
      tcnt_r  <= '0;
      skip_r  <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
      lcnt_r  <= lcnt_nxt;
      tcnt_r  <= tcnt_nxt;
      skip_r  <= skip_nxt;
    end
  end

endmodule

### hw/rtl/kvt_queue.sv
// Short register queue of per-byte result lists between front and back.
module kvt_queue import kvt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic not_full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_pop;

  assign not_full  = cnt_r != CW'(QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rp_r];

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ptr_inc(wp_r);
      if (do_pop) rp_r <= ptr_inc(rp_r);
      if (push && !do_pop) cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

### hw/rtl/kvt_back.sv
// Back stage: emits queued results, one per cycle while out_ready is high.
module kvt_back import kvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       take;
  logic       at_end;

  assign out_valid = q_valid;
  assign out_data  = q_head.res[idx_r];
  assign take      = q_valid && out_ready;
  assign at_end    = ({1'b0, idx_r} + 3'd1) == q_head.cnt;
  assign q_pop     = take && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (take) idx_nxt = at_end ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

endmodule

### hw/rtl/kvt_checker.sv
// Port-level checks of the key/value line tokenizer, bound to the top level.
module kvt_checker import kvt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input item changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == EV_ACCEPT || out_data.event_res == EV_REJECT)
    |-> out_data.last)
    else $error("line verdict not marked last");

  a_total_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_res != EV_ACCEPT |-> out_data.token_total == '0)
    else $error("token total outside an accepted line verdict");

endmodule

bind key_value_line_tokenizer kvt_checker u_kvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
